>>> design/tcw_pkg.sv
// Shared constants for the text console character writer.
package tcw_pkg;

  localparam int CELL_W      = 16;
  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int ROW_FIELD_W = 5;
  localparam int COL_FIELD_W = 7;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

  localparam logic ACTION_PUT  = 1'b0;
  localparam logic ACTION_READ = 1'b1;

endpackage

>>> design/tcw_cell_store.sv
// Cell memory of the console with its row-rotated address unit.
module tcw_cell_store #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic                          direct_i,
  input  logic [$clog2(COLUMNS*ROWS)-1:0] direct_addr_i,
  input  logic [$clog2(ROWS)-1:0]       row_i,
  input  logic [$clog2(COLUMNS)-1:0]    col_i,
  input  logic [$clog2(COLUMNS*ROWS)-1:0] base_i,
  input  logic [tcw_pkg::CELL_W-1:0]    wdata_i,
  output logic [tcw_pkg::CELL_W-1:0]    rdata_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int AW1   = AW + 1;

  logic [tcw_pkg::CELL_W-1:0] mem [CELLS];
  logic [tcw_pkg::CELL_W-1:0] rdata_q;
  logic [AW1-1:0]             lin;
  logic [AW1-1:0]             sum;
  logic [AW1-1:0]             wrapped;
  logic [AW-1:0]              addr;

  // The logical row is rotated by the physical start of the top row, so a
  // scroll only moves the base and never copies cells.
  always_comb begin
    lin     = AW1'(row_i) * AW1'(COLUMNS) + AW1'(col_i);
    sum     = lin + {1'b0, base_i};
    wrapped = (sum >= AW1'(CELLS)) ? (sum - AW1'(CELLS)) : sum;
    addr    = direct_i ? direct_addr_i : wrapped[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr] <= wdata_i;
    end
    rdata_q <= mem[addr];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/text_console_char_writer_core.sv
// Top level of the character-cell text console with its command sequencer.
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ----------------------------------------------
//  command   in         start_i / busy_o     action_i, char_code_i, read_row_i, read_column_i
//  result    out        done_o (one cycle)   cursor_column_out_o, cursor_row_out_o,
//                                            scrolled_o, read_glyph_o, read_attribute_o
//  config    in         cfg_we_i             cfg_wdata_i (text attribute)
//
// A put item writes its cell (a newline writes none) at the accepting edge, and unless it scrolls
// its result is strobed in the next cycle. A read item passes the registered memory read and then
// the result registers. A put or newline that moves down from the last row first zeroes the new
// bottom row with a sweep of one cell per cycle, and its result is strobed when the sweep ends.
// After reset the block clears all COLUMNS * ROWS cells, one per cycle, with busy_o high.
// The receiver cannot stall: each result is valid for exactly the cycle done_o is high.
module text_console_char_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               action_i,
  input  logic [tcw_pkg::CHAR_W-1:0]         char_code_i,
  input  logic [tcw_pkg::ROW_FIELD_W-1:0]    read_row_i,
  input  logic [tcw_pkg::COL_FIELD_W-1:0]    read_column_i,
  input  logic                               cfg_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0]         cfg_wdata_i,
  output logic                               done_o,
  output logic [tcw_pkg::COL_FIELD_W-1:0]    cursor_column_out_o,
  output logic [tcw_pkg::ROW_FIELD_W-1:0]    cursor_row_out_o,
  output logic                               scrolled_o,
  output logic [tcw_pkg::CHAR_W-1:0]         read_glyph_o,
  output logic [tcw_pkg::ATTR_W-1:0]         read_attribute_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int AW1   = AW + 1;
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CLEAR
  } state_e;

  state_e                      state_q;
  logic [CW-1:0]               col_q;
  logic [RW-1:0]               row_q;
  logic [AW-1:0]               base_q;
  logic [AW-1:0]               clr_q;
  logic [AW-1:0]               clr_end_q;
  logic [tcw_pkg::ATTR_W-1:0]  attr_q;
  logic                        done_q;
  logic                        scrolled_q;
  logic                        in_range_q;
  logic [tcw_pkg::CHAR_W-1:0]  glyph_q;
  logic [tcw_pkg::ATTR_W-1:0]  rattr_q;

  logic                        accept;
  logic                        is_put;
  logic                        is_newline;
  logic                        at_last_col;
  logic                        at_last_row;
  logic                        in_range;
  logic [RW+tcw_pkg::ROW_FIELD_W-1:0] rd_row_ext;
  logic [CW+tcw_pkg::COL_FIELD_W-1:0] rd_col_ext;
  logic [RW-1:0]               sel_row;
  logic [CW-1:0]               sel_col;
  logic [AW1-1:0]              base_step;
  logic [AW-1:0]               base_d;
  logic                        store_we;
  logic                        store_direct;
  logic [tcw_pkg::CELL_W-1:0]  store_wdata;
  logic [tcw_pkg::CELL_W-1:0]  store_rdata;
  logic [CW+tcw_pkg::COL_FIELD_W-1:0] col_out_ext;
  logic [RW+tcw_pkg::ROW_FIELD_W-1:0] row_out_ext;

  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign is_put      = (action_i == tcw_pkg::ACTION_PUT);
  assign is_newline  = (char_code_i == tcw_pkg::NEWLINE_CODE);
  assign at_last_col = (col_q == CW'(COLUMNS - 1));
  assign at_last_row = (row_q == RW'(ROWS - 1));

  // Reads outside the grid return a zero cell.
  assign in_range = ({27'd0, read_row_i} < 32'(ROWS)) &&
                    ({25'd0, read_column_i} < 32'(COLUMNS));
  assign rd_row_ext = {{RW{1'b0}}, read_row_i};
  assign rd_col_ext = {{CW{1'b0}}, read_column_i};

  assign sel_row = is_put ? row_q : rd_row_ext[RW-1:0];
  assign sel_col = is_put ? col_q : rd_col_ext[CW-1:0];

  // After a scroll the old top row becomes the bottom row, so the base
  // moves forward by one row and wraps at the end of the store.
  assign base_step = {1'b0, base_q} + AW1'(COLUMNS);
  assign base_d    = (base_step == AW1'(CELLS)) ? '0 : base_step[AW-1:0];

  // In the clearing states the sweep counter addresses the store directly.
  assign store_direct = (state_q == ST_INIT) || (state_q == ST_CLEAR);
  assign store_we     = store_direct || (accept && is_put && !is_newline);
  assign store_wdata  = store_direct ? '0 : {attr_q, char_code_i};

  tcw_cell_store #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_store (
    .clk_i        (clk_i),
    .we_i         (store_we),
    .direct_i     (store_direct),
    .direct_addr_i(clr_q),
    .row_i        (sel_row),
    .col_i        (sel_col),
    .base_i       (base_q),
    .wdata_i      (store_wdata),
    .rdata_o      (store_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tcw_pkg::ATTR_RESET;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      col_q      <= '0;
      row_q      <= '0;
      base_q     <= '0;
      clr_q      <= '0;
      clr_end_q  <= AW'(CELLS - 1);
      done_q     <= 1'b0;
      scrolled_q <= 1'b0;
      in_range_q <= 1'b0;
      glyph_q    <= '0;
      rattr_q    <= '0;
    end else begin
      case (state_q)
        ST_INIT: begin
          done_q <= 1'b0;
          if (clr_q == clr_end_q) begin
            state_q <= ST_IDLE;
          end else begin
            clr_q <= clr_q + AW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            glyph_q <= '0;
            rattr_q <= '0;
            if (!is_put) begin
              in_range_q <= in_range;
              scrolled_q <= 1'b0;
              done_q     <= 1'b0;
              state_q    <= ST_READ;
            end else if (is_newline || at_last_col) begin
              // Line feed: back to column 0 and down, scrolling at the bottom.
              col_q <= '0;
              if (at_last_row) begin
                scrolled_q <= 1'b1;
                done_q     <= 1'b0;
                clr_q      <= base_q;
                clr_end_q  <= base_q + AW'(COLUMNS - 1);
                base_q     <= base_d;
                state_q    <= ST_CLEAR;
              end else begin
                row_q      <= row_q + RW'(1);
                scrolled_q <= 1'b0;
                done_q     <= 1'b1;
              end
            end else begin
              col_q      <= col_q + CW'(1);
              scrolled_q <= 1'b0;
              done_q     <= 1'b1;
            end
          end else begin
            done_q <= 1'b0;
          end
        end
        ST_READ: begin
          glyph_q <= in_range_q ? store_rdata[tcw_pkg::CHAR_W-1:0] : '0;
          rattr_q <= in_range_q ? store_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        ST_CLEAR: begin
          if (clr_q == clr_end_q) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            done_q <= 1'b0;
            clr_q  <= clr_q + AW'(1);
          end
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Cursor outputs are reduced to the field widths.
  assign col_out_ext = {{tcw_pkg::COL_FIELD_W{1'b0}}, col_q};
  assign row_out_ext = {{tcw_pkg::ROW_FIELD_W{1'b0}}, row_q};

  assign done_o              = done_q;
  assign cursor_column_out_o = col_out_ext[tcw_pkg::COL_FIELD_W-1:0];
  assign cursor_row_out_o    = row_out_ext[tcw_pkg::ROW_FIELD_W-1:0];
  assign scrolled_o          = scrolled_q;
  assign read_glyph_o        = glyph_q;
  assign read_attribute_o    = rattr_q;

`ifndef ASSERT_OFF
  // A result is only strobed once the sequencer is back to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("result strobed while busy");

  // The cursor never leaves the grid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(col_q) < 32'(COLUMNS)) && (32'(row_q) < 32'(ROWS)))
    else $error("cursor outside grid");

  // A scrolling item leaves the cursor at the start of the last row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && scrolled_o) |-> ((col_q == '0) && at_last_row))
    else $error("scroll left cursor misplaced");

  // An accepted item either finishes next cycle or keeps the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (done_o || busy_o))
    else $error("accepted item dropped");
`endif

endmodule
